@@ sv/sfbc_pkg.sv @@
// Shared constants and types for the slab free block cache.
package sfbc_pkg;
	localparam int ENTRIES      = 32;
	localparam int WASTE_FACTOR = 4;
	localparam int IDX_W        = $clog2(ENTRIES);
	localparam int CNT_W        = $clog2(ENTRIES + 1);
	localparam int LEN_W        = 20;
	localparam int ADDR_W       = 48;
	localparam int OWN_W        = 8;
	localparam int TOT_W        = 25;
	localparam int ENT_W        = ADDR_W + LEN_W + OWN_W;
	localparam logic [20:0] LIMIT_CAP  = 21'h100000;
	localparam logic [24:0] BUDGET_CAP = 25'h1000000;

	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_FREE    = 2'd1;
	localparam logic [1:0] ACT_RECLAIM = 2'd2;

	localparam logic [1:0] REG_MIN    = 2'd0;
	localparam logic [1:0] REG_MAX    = 2'd1;
	localparam logic [1:0] REG_BUDGET = 2'd2;
	localparam logic [1:0] REG_FLUSH  = 2'd3;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [LEN_W-1:0]  len;
		logic [OWN_W-1:0]  owner;
	} entry_t;
endpackage

@@ sv/sfbc_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
module sfbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

@@ sv/slab_free_block_cache_unit.sv @@
// Top level of the slab free block cache: sequencer, entry RAM and shared scan compare.
// Each beat is handled alone and in_stall stays high until the block is idle again. The
// table lives in a RAM of address/length/owner words, newest first, with per-slot valid and
// previous bits in flops, so reset empties it at once. One RAM read per cycle sets the pace.
// An allocate first scans the current generation and stops early on an own-thread match.
// On a miss it scans again for previous entries of exact size. A hit then fetches the entry
// and shifts the later entries down one slot to close the gap. A cached free shifts the
// table up one slot per cycle and then writes the new entry at slot 0. A released free
// passes the block address straight out with release set. A reclaim steps over the current
// entries and releases each previous entry in turn; a reclaim that is skipped gives no
// result. Results leave through one output register, and a stall there holds the block
// until the result is taken.
module slab_free_block_cache_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  action,
	input  logic [31:0]                 block_size,
	input  logic [47:0]                 block_addr,
	input  logic [7:0]                  thread_id,
	input  logic [31:0]                 now_ms,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        hit,
	output logic [47:0]                 result_addr,
	output logic [31:0]                 actual_size,
	output logic                        release_res,
	output logic                        last,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [31:0]                 cfg_data
);
	import sfbc_pkg::*;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCAN  = 4'd1; // allocate search, current then previous
	localparam logic [3:0] S_FETCH = 4'd2; // read the chosen entry
	localparam logic [3:0] S_TAKE  = 4'd3;
	localparam logic [3:0] S_DEL   = 4'd4; // shift down over removed slot
	localparam logic [3:0] S_INS   = 4'd5; // shift up to open slot 0
	localparam logic [3:0] S_PUT   = 4'd6; // write the new entry at slot 0
	localparam logic [3:0] S_REC   = 4'd7; // walk to the previous entries
	localparam logic [3:0] S_REL   = 4'd8; // one release beat
	localparam logic [3:0] S_OUT   = 4'd9;

	logic [3:0] state_q;
	logic [12:0] min_q;
	logic [20:0] max_q;
	logic [24:0] budget_q;
	logic [15:0] flush_q;
	logic [TOT_W-1:0] total_q;
	logic [31:0] flush_time_q;
	logic [ENTRIES-1:0] valid_q, prev_q;
	logic [CNT_W-1:0] cnt_q, idx_q, ncur_q;
	logic pass_q, cand_ok_q, rd_pend_q, rec_q;
	logic [IDX_W-1:0] cand_q, rd_idx_q;
	logic [31:0] size_q;
	logic [33:0] top_q;
	logic [OWN_W-1:0] tid_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0] ilen_q;

	// RAM port
	logic we;
	logic [IDX_W-1:0] waddr, raddr;
	entry_t wdata, rdata;

	sfbc_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign cfg_ready = (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);

	// request rounded up to the minimum, and the top of the waste window
	logic [31:0] size_c;
	logic [33:0] top_c;
	assign size_c = (block_size < {19'd0, min_q}) ? {19'd0, min_q} : block_size;
	assign top_c  = 34'(size_c) * 34'(WASTE_FACTOR);

	logic [20:0] limit;
	logic [24:0] budget;
	logic free_ok, age_ok;
	assign limit   = (max_q > LIMIT_CAP) ? LIMIT_CAP : max_q;
	assign budget  = (budget_q > BUDGET_CAP) ? BUDGET_CAP : budget_q;
	assign free_ok = block_size < {11'd0, limit} && total_q < budget
	                 && cnt_q < CNT_W'(ENTRIES);
	assign age_ok  = (now_ms - flush_time_q) >= {16'd0, flush_q};

	// shared compare on the entry read last cycle
	logic match, own_hit, more, scan_done;
	always_comb begin
		if (!pass_q) match = rd_pend_q && !prev_q[rd_idx_q] && {12'd0, rdata.len} >= size_q
		                     && {14'd0, rdata.len} <= top_q;
		else match = rd_pend_q && prev_q[rd_idx_q] && {12'd0, rdata.len} == size_q;
	end
	assign own_hit   = match && (rdata.owner == tid_q);
	assign more      = (idx_q < cnt_q);
	assign scan_done = own_hit || !more;

	// slots below the removed one keep their previous bit
	logic [ENTRIES-1:0] keep_lo;
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) keep_lo[i] = (IDX_W'(i) < cand_q);
	end

	logic [IDX_W-1:0] ins_rd;
	assign ins_rd = idx_q[IDX_W-1:0] - 1'b1;

	always_comb begin
		we = 1'b0; waddr = rd_idx_q; wdata = rdata;
		raddr = idx_q[IDX_W-1:0];
		unique case (state_q)
			S_FETCH: raddr = cand_q;
			S_DEL: begin
				we = rd_pend_q; waddr = rd_idx_q - 1'b1;
			end
			S_INS: begin
				we = rd_pend_q; waddr = rd_idx_q + 1'b1; raddr = ins_rd;
			end
			S_PUT: begin
				we = 1'b1; waddr = '0; wdata = {addr_q, ilen_q, tid_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			min_q <= 13'd24; max_q <= LIMIT_CAP; budget_q <= BUDGET_CAP; flush_q <= 16'd2000;
			total_q <= '0; flush_time_q <= '0; valid_q <= '0; prev_q <= '0; cnt_q <= '0;
			idx_q <= '0; ncur_q <= '0; pass_q <= 1'b0; cand_ok_q <= 1'b0; rd_pend_q <= 1'b0;
			rec_q <= 1'b0; cand_q <= '0; rd_idx_q <= '0; size_q <= '0; top_q <= '0;
			tid_q <= '0; addr_q <= '0; ilen_q <= '0;
			out_valid <= 1'b0; hit <= 1'b0; result_addr <= '0; actual_size <= '0;
			release_res <= 1'b0; last <= 1'b1;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					REG_MIN:    min_q <= cfg_data[12:0];
					REG_MAX:    max_q <= cfg_data[20:0];
					REG_BUDGET: budget_q <= cfg_data[24:0];
					REG_FLUSH:  flush_q <= cfg_data[15:0];
				endcase
			end
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					tid_q <= thread_id; addr_q <= block_addr; ilen_q <= block_size[LEN_W-1:0];
					size_q <= size_c; top_q <= top_c;
					idx_q <= '0; ncur_q <= '0; pass_q <= 1'b0; cand_ok_q <= 1'b0;
					rd_pend_q <= 1'b0; rec_q <= 1'b0;
					hit <= 1'b0; result_addr <= '0; actual_size <= '0; release_res <= 1'b0;
					last <= 1'b1;
					unique case (action)
						ACT_ALLOC: state_q <= S_SCAN;
						ACT_FREE: begin
							if (free_ok) begin
								idx_q <= cnt_q; state_q <= S_INS;
							end else begin
								result_addr <= block_addr; release_res <= 1'b1;
								out_valid <= 1'b1; state_q <= S_OUT;
							end
						end
						ACT_RECLAIM: begin
							if (cnt_q != '0 && age_ok) begin
								flush_time_q <= now_ms; rec_q <= 1'b1; state_q <= S_REC;
							end
						end
						default: ;
					endcase
				end
				S_SCAN: begin
					// later matches are older; an own-thread match ends the pass
					if (match) begin
						cand_q <= rd_idx_q; cand_ok_q <= 1'b1;
					end
					if (!scan_done) begin
						rd_idx_q <= idx_q[IDX_W-1:0]; rd_pend_q <= 1'b1; idx_q <= idx_q + 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						if (cand_ok_q || match) state_q <= S_FETCH;
						else if (!pass_q) begin
							pass_q <= 1'b1; idx_q <= '0;
						end else begin
							actual_size <= size_q; out_valid <= 1'b1; state_q <= S_OUT;
						end
					end
				end
				S_FETCH: state_q <= S_TAKE;
				S_TAKE: begin
					hit <= 1'b1; result_addr <= rdata.addr;
					actual_size <= {12'd0, rdata.len};
					total_q <= total_q - {5'd0, rdata.len};
					idx_q <= {1'b0, cand_q} + 1'b1; rd_pend_q <= 1'b0; state_q <= S_DEL;
				end
				S_DEL: begin
					if (more) begin
						rd_idx_q <= idx_q[IDX_W-1:0]; rd_pend_q <= 1'b1; idx_q <= idx_q + 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						valid_q <= valid_q >> 1;
						prev_q <= (prev_q & keep_lo) | ((prev_q >> 1) & ~keep_lo);
						cnt_q <= cnt_q - 1'b1;
						out_valid <= 1'b1; state_q <= S_OUT;
					end
				end
				S_INS: begin
					if (idx_q != '0) begin
						rd_idx_q <= ins_rd; rd_pend_q <= 1'b1; idx_q <= idx_q - 1'b1;
					end else begin
						rd_pend_q <= 1'b0; state_q <= S_PUT;
					end
				end
				S_PUT: begin
					valid_q <= {valid_q[ENTRIES-2:0], 1'b1};
					prev_q <= {prev_q[ENTRIES-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					total_q <= total_q + {5'd0, ilen_q};
					out_valid <= 1'b1; state_q <= S_OUT;
				end
				S_REC: begin
					// current entries come first; the rest are all previous
					if (!more) begin
						valid_q <= valid_q & ~prev_q; prev_q <= valid_q & ~prev_q;
						cnt_q <= ncur_q; rec_q <= 1'b0; state_q <= S_IDLE;
					end else if (!prev_q[idx_q[IDX_W-1:0]]) begin
						idx_q <= idx_q + 1'b1; ncur_q <= idx_q + 1'b1;
					end else state_q <= S_REL;
				end
				S_REL: begin
					result_addr <= rdata.addr; release_res <= 1'b1;
					last <= (idx_q + 1'b1 == cnt_q);
					total_q <= total_q - {5'd0, rdata.len};
					idx_q <= idx_q + 1'b1; out_valid <= 1'b1; state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= rec_q ? S_REC : S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// valid entries stay compact
	a_compact: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q & (valid_q + 1'b1)) == '0) else $error("table not compact");

	a_prev: assert property (@(posedge clk) disable iff (!arst_n)
		(prev_q & ~valid_q) == '0) else $error("previous bit on empty slot");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(cnt_q)) else $error("entry count out of step");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("result pending while idle");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready |-> !out_valid) else $error("config open while result pending");
endmodule
